>>> hw/rtl/json_text_to_font_utf8_assert.svh
// Assertion macros for the text transcoder.
`ifndef JSON_TEXT_TO_FONT_UTF8_ASSERT_SVH
`define JSON_TEXT_TO_FONT_UTF8_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define JTFU_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) else $error(msg);

// Condition in one cycle implies a result in the next one.
`define JTFU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/jtfu_pkg.sv
package jtfu_pkg;

    localparam int MAX_TEXT_BYTES_DEF = 1023;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [9:0] CAPACITY_RST = 10'd64;

    localparam logic [15:0] SURR_LO = 16'hD800;
    localparam logic [15:0] SURR_HI = 16'hDFFF;

    typedef enum logic {
        TK_CP,
        TK_END
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind   kind;
        logic [15:0] cp;
    } t_token;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_seq;

    function automatic logic f_is_space(input logic [15:0] c);
        return c == 16'h0020 || c == 16'h0009 || c == 16'h000A || c == 16'h000D ||
               c == 16'h00A0 || c == 16'h2007 || c == 16'h2009 || c == 16'h202F;
    endfunction

    // Bytes written for one code point: font glyphs as UTF-8, others folded to ASCII or dropped.
    function automatic t_seq f_seq(input logic [15:0] c);
        t_seq s;
        logic font;
        s = '0;
        font = (c >= 16'h0020 && c <= 16'h007E);
        case (c)
            16'h00B0, 16'h00B3, 16'h00B5, 16'h00C1, 16'h00E1, 16'h00C9, 16'h00E9,
            16'h00CD, 16'h00ED, 16'h00D3, 16'h00F3, 16'h00DA, 16'h00FA, 16'h00DD,
            16'h00FD, 16'h010C, 16'h010D, 16'h010E, 16'h010F, 16'h011A,
            16'h011B, 16'h0147, 16'h0148, 16'h0158, 16'h0159, 16'h0160,
            16'h0161, 16'h0164, 16'h0165, 16'h016E, 16'h016F, 16'h017D,
            16'h017E, 16'h2082: font = 1'b1;
            default: ;
        endcase
        if (font) begin
            if (c < 16'h0080) begin
                s = {2'd1, c[7:0], 16'h0000};
            end else if (c < 16'h0800) begin
                s = {2'd2, 3'b110, c[10:6], 2'b10, c[5:0], 8'h00};
            end else begin
                s = {2'd3, 4'hE, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0]};
            end
        end else begin
            case (c)
                16'h00C4, 16'h00C0, 16'h00C2, 16'h00C3, 16'h00C5, 16'h0104:
                    s = {2'd1, "A", 16'h0000};
                16'h00E4, 16'h00E0, 16'h00E2, 16'h00E3, 16'h00E5, 16'h0105:
                    s = {2'd1, "a", 16'h0000};
                16'h00D6, 16'h00D2, 16'h00D4, 16'h00D5: s = {2'd1, "O", 16'h0000};
                16'h00F6, 16'h00F2, 16'h00F4, 16'h00F5: s = {2'd1, "o", 16'h0000};
                16'h00DC, 16'h00D9, 16'h00DB: s = {2'd1, "U", 16'h0000};
                16'h00FC, 16'h00F9, 16'h00FB: s = {2'd1, "u", 16'h0000};
                16'h00DF: s = {2'd2, "s", "s", 8'h00};
                16'h00C8, 16'h00CA, 16'h00CB, 16'h0118: s = {2'd1, "E", 16'h0000};
                16'h00E8, 16'h00EA, 16'h00EB, 16'h0119: s = {2'd1, "e", 16'h0000};
                16'h00CC, 16'h00CE, 16'h00CF: s = {2'd1, "I", 16'h0000};
                16'h00EC, 16'h00EE, 16'h00EF: s = {2'd1, "i", 16'h0000};
                16'h00C7, 16'h0106: s = {2'd1, "C", 16'h0000};
                16'h00E7, 16'h0107: s = {2'd1, "c", 16'h0000};
                16'h00D1, 16'h0143: s = {2'd1, "N", 16'h0000};
                16'h00F1, 16'h0144: s = {2'd1, "n", 16'h0000};
                16'h0139, 16'h013D, 16'h0141: s = {2'd1, "L", 16'h0000};
                16'h013A, 16'h013E, 16'h0142: s = {2'd1, "l", 16'h0000};
                16'h0154: s = {2'd1, "R", 16'h0000};
                16'h0155: s = {2'd1, "r", 16'h0000};
                16'h015A: s = {2'd1, "S", 16'h0000};
                16'h015B: s = {2'd1, "s", 16'h0000};
                16'h0179, 16'h017B: s = {2'd1, "Z", 16'h0000};
                16'h017A, 16'h017C: s = {2'd1, "z", 16'h0000};
                16'h2010, 16'h2011, 16'h2012, 16'h2013, 16'h2014, 16'h2015,
                16'h2212: s = {2'd1, "-", 16'h0000};
                16'h2018, 16'h2019, 16'h201A, 16'h201B: s = {2'd1, "'", 16'h0000};
                16'h201C, 16'h201D, 16'h201E, 16'h201F, 16'h00AB, 16'h00BB:
                    s = {2'd1, 8'h22, 16'h0000};
                16'h2026: s = {2'd3, ".", ".", "."};
                16'h20AC: s = {2'd3, "E", "U", "R"};
                16'h00A9: s = {2'd3, "(", "c", ")"};
                default: s = '0;
            endcase
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/json_text_to_font_utf8.sv
// JSON string body to display-font UTF-8 text.
// Input channel: i_in_valid / o_in_stall with i_in_byte, i_byte_present and
// i_last_byte; a transfer happens when valid is high and stall is low. A
// transfer with neither byte nor last flag is taken and gives nothing.
// Output channel: o_out_valid / i_out_stall; each transfer is one destination
// byte with its position, and the end of a text gives a terminator with
// o_last_result and o_text_length.
// Capacity is written with i_cfg_wr_en / i_cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Throughput: the front issues one token (decoded code point or end mark) per
// cycle while the queue takes it, and an input gives up to 5 tokens there; the
// back takes a token and gives all of its output bytes, up to 4 bytes per code
// point, before it takes the next. A 4-entry token queue sits between them.
// Reset (synchronous, active low) clears decoder state and the count and sets
// capacity to 64. A stalled output holds its transfer; the queue fills and
// then o_in_stall rises.
module json_text_to_font_utf8 #(
    parameter int MAX_TEXT_BYTES = jtfu_pkg::MAX_TEXT_BYTES_DEF,
    parameter int QUEUE_DEPTH    = jtfu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [9:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_byte_present,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [9:0] o_position,
    output logic       o_is_terminator,
    output logic       o_store_enable,
    output logic       o_last_result,
    output logic [9:0] o_text_length
);

    jtfu_pkg::t_token f_tok, q_tok;
    logic             f_valid, f_stall, q_valid, q_stall;

    jtfu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_byte_present (i_byte_present),
        .i_last_byte    (i_last_byte),
        .o_tok_valid    (f_valid),
        .i_tok_stall    (f_stall),
        .o_tok          (f_tok)
    );

    jtfu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_tok   (f_tok),
        .o_valid (q_valid),
        .i_stall (q_stall),
        .o_tok   (q_tok)
    );

    jtfu_back #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_tok_valid     (q_valid),
        .o_tok_stall     (q_stall),
        .i_tok           (q_tok),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_position      (o_position),
        .o_is_terminator (o_is_terminator),
        .o_store_enable  (o_store_enable),
        .o_last_result   (o_last_result),
        .o_text_length   (o_text_length)
    );

endmodule

>>> hw/rtl/jtfu_front.sv
module jtfu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_in_byte,
    input  logic            i_byte_present,
    input  logic            i_last_byte,
    output logic            o_tok_valid,
    input  logic            i_tok_stall,
    output jtfu_pkg::t_token o_tok
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_UTF8,
        M_ESC,
        M_HEX
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [1:0]       r_cl, n_cl;
    logic [20:0]      r_acc, n_acc;
    logic [1:0]       r_hc, n_hc;
    logic [7:0]       r_held [3];
    logic [7:0]       n_held [3];
    logic [4:0]       r_slot_v, n_slot_v;
    jtfu_pkg::t_token r_slot [5];
    jtfu_pkg::t_token n_slot [5];

    logic       accept, push, single;
    logic [4:0] first;

    assign o_tok_valid = |r_slot_v;
    assign push        = o_tok_valid && !i_tok_stall;
    assign single      = (r_slot_v & (r_slot_v - 5'd1)) == 5'd0;
    assign o_stall     = o_tok_valid && !(push && single);
    assign accept      = i_valid && !o_stall;
    assign first       = r_slot_v & (~r_slot_v + 5'd1);

    always_comb begin
        o_tok = r_slot[4];
        for (int k = 3; k >= 0; k--) begin
            if (r_slot_v[k]) o_tok = r_slot[k];
        end
    end

    always_comb begin
        logic        fresh, cp_v, hex_ok;
        logic [15:0] cp;
        logic [1:0]  rep_n, cl_new;
        logic [3:0]  d;
        logic [20:0] acc6;
        logic [15:0] acc4;
        logic [7:0]  b;
        fresh  = 1'b0;
        cp_v   = 1'b0;
        cp     = '0;
        rep_n  = 2'd0;
        b      = i_in_byte;
        n_mode = r_mode;
        n_cl   = r_cl;
        n_acc  = r_acc;
        n_hc   = r_hc;
        n_held = r_held;
        hex_ok = 1'b1;
        d      = 4'd0;
        if (b >= "0" && b <= "9")      d = 4'(b - "0");
        else if (b >= "a" && b <= "f") d = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F") d = 4'(b - "A" + 8'd10);
        else                           hex_ok = 1'b0;
        acc6   = {r_acc[14:0], b[5:0]};
        acc4   = {r_acc[11:0], d};
        cl_new = (r_cl != 2'd0) ? r_cl - 2'd1 : r_cl;

        if (i_byte_present) begin
            case (r_mode)
                M_UTF8: begin
                    if (b[7:6] == 2'b10) begin
                        n_acc = acc6;
                        n_cl  = cl_new;
                        if (cl_new == 2'd0) begin
                            n_mode = M_IDLE;
                            if (acc6[20:16] == 5'd0) begin
                                cp_v = 1'b1;
                                cp   = acc6[15:0];
                            end
                        end
                    end else begin
                        fresh = 1'b1;
                    end
                end
                M_ESC: begin
                    n_mode = M_IDLE;
                    if (b == 8'h22 || b == 8'h5C || b == "/") begin
                        cp_v = 1'b1;
                        cp   = {8'h00, b};
                    end else if (b == "b" || b == "f" || b == "n" || b == "r" || b == "t") begin
                        cp_v = 1'b1;
                        cp   = 16'h0020;
                    end else if (b == "u") begin
                        n_mode = M_HEX;
                        n_hc   = 2'd0;
                        n_acc  = '0;
                    end
                end
                M_HEX: begin
                    if (hex_ok) begin
                        n_acc = {5'd0, acc4};
                        if (r_hc == 2'd3) begin
                            n_mode = M_IDLE;
                            n_hc   = 2'd0;
                            if (acc4 < jtfu_pkg::SURR_LO || acc4 > jtfu_pkg::SURR_HI) begin
                                cp_v = 1'b1;
                                cp   = acc4;
                            end
                        end else begin
                            n_held[r_hc] = b;
                            n_hc         = r_hc + 2'd1;
                        end
                    end else begin
                        rep_n = r_hc;
                        n_hc  = 2'd0;
                        fresh = 1'b1;
                    end
                end
                default: fresh = 1'b1;
            endcase
            if (fresh) begin
                n_mode = M_IDLE;
                if (b == 8'h5C) begin
                    n_mode = M_ESC;
                end else if (!b[7]) begin
                    cp_v = 1'b1;
                    cp   = {8'h00, b};
                end else if (b[7:5] == 3'b110) begin
                    n_acc  = {16'd0, b[4:0]};
                    n_cl   = 2'd1;
                    n_mode = M_UTF8;
                end else if (b[7:4] == 4'b1110) begin
                    n_acc  = {17'd0, b[3:0]};
                    n_cl   = 2'd2;
                    n_mode = M_UTF8;
                end else if (b[7:3] == 5'b11110) begin
                    n_acc  = {18'd0, b[2:0]};
                    n_cl   = 2'd3;
                    n_mode = M_UTF8;
                end
            end
        end

        if (i_last_byte) begin
            if (n_mode == M_HEX) rep_n = n_hc;
            n_mode = M_IDLE;
            n_cl   = 2'd0;
            n_acc  = '0;
            n_hc   = 2'd0;
        end

        for (int k = 0; k < 3; k++) begin
            n_slot[k] = {jtfu_pkg::TK_CP, 8'h00, n_held[k]};
        end
        n_slot[3] = {jtfu_pkg::TK_CP, cp};
        n_slot[4] = {jtfu_pkg::TK_END, 16'h0000};

        if (accept) begin
            n_slot_v = {i_last_byte, cp_v, rep_n == 2'd3, rep_n >= 2'd2, rep_n >= 2'd1};
        end else if (push) begin
            n_slot_v = r_slot_v & ~first;
        end else begin
            n_slot_v = r_slot_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_cl     <= '0;
            r_acc    <= '0;
            r_hc     <= '0;
            r_slot_v <= '0;
        end else begin
            r_slot_v <= n_slot_v;
            if (accept) begin
                r_mode <= n_mode;
                r_cl   <= n_cl;
                r_acc  <= n_acc;
                r_hc   <= n_hc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
            r_slot <= n_slot;
        end
    end

endmodule

>>> hw/rtl/jtfu_queue.sv
module jtfu_queue #(
    parameter int DEPTH = jtfu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  jtfu_pkg::t_token i_tok,
    output logic             o_valid,
    input  logic             i_stall,
    output jtfu_pkg::t_token o_tok
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jtfu_pkg::t_token r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr, rd;

    assign o_stall = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_tok   = r_mem[r_rp];
    assign wr      = i_valid && !o_stall;
    assign rd      = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (rd) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            if (wr && !rd)      r_cnt <= r_cnt + CW'(1);
            else if (rd && !wr) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_tok;
    end

endmodule

>>> hw/rtl/jtfu_back.sv
`include "json_text_to_font_utf8_assert.svh"

module jtfu_back #(
    parameter int MAX_TEXT_BYTES = jtfu_pkg::MAX_TEXT_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [9:0]       i_cfg_wr_data,
    input  logic             i_tok_valid,
    output logic             o_tok_stall,
    input  jtfu_pkg::t_token i_tok,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_byte,
    output logic [9:0]       o_position,
    output logic             o_is_terminator,
    output logic             o_store_enable,
    output logic             o_last_result,
    output logic [9:0]       o_text_length
);

    localparam logic [15:0] LP_MAX = 16'(MAX_TEXT_BYTES);

    logic [9:0] r_cap;
    logic [9:0] r_wc;
    logic       r_sp, r_aw;
    logic [7:0] r_bytes [4];
    logic [2:0] r_cnt;
    logic [1:0] r_idx;
    logic [9:0] r_base;
    logic       r_term, r_st;

    logic          pop, mv, extra, fits, is_end;
    logic [9:0]    cap_eff;
    logic [10:0]   need;
    logic [2:0]    total;
    jtfu_pkg::t_seq seq;

    assign o_tok_stall = r_cnt != 3'd0;
    assign pop     = i_tok_valid && (r_cnt == 3'd0);
    assign mv      = (r_cnt != 3'd0) && (!o_valid || !i_stall);
    assign is_end  = i_tok.kind == jtfu_pkg::TK_END;
    assign cap_eff = ({6'd0, r_cap} < LP_MAX) ? r_cap : LP_MAX[9:0];
    assign seq     = jtfu_pkg::f_seq(i_tok.cp);
    assign extra   = r_sp && r_aw;
    assign total   = {1'b0, seq.len} + {2'b00, extra};
    assign need    = {1'b0, r_wc} + {8'd0, total} + 11'd1;
    assign fits    = need <= {1'b0, cap_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= jtfu_pkg::CAPACITY_RST;
            r_wc    <= '0;
            r_sp    <= 1'b0;
            r_aw    <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;
            if (pop) begin
                r_idx <= '0;
                if (is_end) begin
                    r_cnt <= 3'd1;
                    r_wc  <= '0;
                    r_sp  <= 1'b0;
                    r_aw  <= 1'b0;
                end else if (jtfu_pkg::f_is_space(i_tok.cp)) begin
                    if (r_aw) r_sp <= 1'b1;
                end else if (seq.len != 2'd0 && fits) begin
                    r_cnt <= total;
                    r_wc  <= r_wc + {7'd0, total};
                    r_sp  <= 1'b0;
                    r_aw  <= 1'b1;
                end
            end
            if (mv) begin
                o_valid <= 1'b1;
                r_idx   <= r_idx + 2'd1;
                if ({1'b0, r_idx} + 3'd1 == r_cnt) r_cnt <= '0;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_base <= r_wc;
            r_term <= is_end;
            r_st   <= cap_eff != 10'd0;
            if (is_end) begin
                r_bytes[0] <= 8'h00;
            end else if (extra) begin
                r_bytes[0] <= 8'h20;
                r_bytes[1] <= seq.b0;
                r_bytes[2] <= seq.b1;
                r_bytes[3] <= seq.b2;
            end else begin
                r_bytes[0] <= seq.b0;
                r_bytes[1] <= seq.b1;
                r_bytes[2] <= seq.b2;
            end
        end
        if (mv) begin
            o_out_byte      <= r_bytes[r_idx];
            o_position      <= r_base + {8'd0, r_idx};
            o_is_terminator <= r_term;
            o_last_result   <= r_term;
            o_store_enable  <= r_term ? r_st : 1'b1;
            o_text_length   <= r_term ? r_base : 10'd0;
        end
    end

    `JTFU_ASSERT(a_cnt_range, r_cnt <= 3'd4, "byte buffer count out of range")
    `JTFU_ASSERT(a_wc_range, r_wc <= 10'd1022, "written count past destination")
    `JTFU_ASSERT(a_term_len, (o_valid && o_is_terminator) |-> (o_text_length == o_position), "terminator length mismatch")
    `JTFU_ASSERT_NEXT(a_end_clears, pop && is_end, r_wc == 10'd0 && !r_aw && !r_sp, "text state not cleared at end")

endmodule

>>> tb/sv/json_text_to_font_utf8_tb.sv
module json_text_to_font_utf8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 24;

    localparam logic [1:0] DEC_IDLE = 2'd0;
    localparam logic [1:0] DEC_UTF8 = 2'd1;
    localparam logic [1:0] DEC_ESC  = 2'd2;
    localparam logic [1:0] DEC_HEX  = 2'd3;

    typedef struct {
        logic [7:0] b;
        logic       present;
        logic       last;
    } t_src;

    typedef struct {
        logic [7:0] b;
        logic [9:0] pos;
        logic       term;
        logic       st;
        logic       last;
        logic [9:0] len;
    } t_wr;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [9:0] i_cfg_wr_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_byte_present;
    logic       i_last_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic [9:0] o_position;
    logic       o_is_terminator;
    logic       o_store_enable;
    logic       o_last_result;
    logic [9:0] o_text_length;

    json_text_to_font_utf8 u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_byte_present (i_byte_present),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_position     (o_position),
        .o_is_terminator(o_is_terminator),
        .o_store_enable (o_store_enable),
        .o_last_result  (o_last_result),
        .o_text_length  (o_text_length)
    );

    t_src src_q[$];
    t_wr  dest_writes_q[$];
    int   n_items;
    int   n_errors;
    int   cycles;
    int   src_gap_max;
    int   sink_stall_max;
    int   src_gap;
    int   sink_stall;

    // predictor state
    logic [9:0]  p_capacity;
    logic [1:0]  p_mode;
    logic [1:0]  p_cont_left;
    logic [20:0] p_acc;
    int          p_hex_cnt;
    logic [7:0]  p_hex_held[3];
    logic [9:0]  p_written;
    logic        p_space_pend;
    logic        p_any_written;

    function automatic void push_write(logic [7:0] b, logic [9:0] pos, logic term, logic st,
                                       logic last, logic [9:0] len);
        t_wr w;
        w.b = b; w.pos = pos; w.term = term; w.st = st; w.last = last; w.len = len;
        dest_writes_q.push_back(w);
    endfunction

    function automatic void put_seq(logic [2:0][7:0] s, int n);
        int extra;
        if (n == 0) return;
        extra = (p_space_pend && p_any_written) ? 1 : 0;
        if (int'(p_written) + n + extra + 1 > int'(p_capacity)) return;
        if (extra == 1) begin
            push_write(8'h20, p_written, 1'b0, 1'b1, 1'b0, 10'd0);
            p_written++;
        end
        for (int i = 0; i < n; i++) begin
            push_write(s[2-i], p_written, 1'b0, 1'b1, 1'b0, 10'd0);
            p_written++;
        end
        p_space_pend = 1'b0;
        p_any_written = 1'b1;
    endfunction

    function automatic logic glyph_in_font(logic [20:0] c);
        if (c >= 21'h20 && c <= 21'h7E) return 1'b1;
        case (c)
            21'hB0, 21'hB3, 21'hB5, 21'hC1, 21'hE1, 21'hC9, 21'hE9, 21'hCD, 21'hED,
            21'hD3, 21'hF3, 21'hDA, 21'hFA, 21'hDD, 21'hFD, 21'h10C, 21'h10D, 21'h10E,
            21'h10F, 21'h11A, 21'h11B, 21'h147, 21'h148, 21'h158, 21'h159, 21'h160,
            21'h161, 21'h164, 21'h165, 21'h16E, 21'h16F, 21'h17D, 21'h17E,
            21'h2082: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic string ascii_fold(logic [20:0] c);
        case (c)
            21'hC4, 21'hC0, 21'hC2, 21'hC3, 21'hC5, 21'h104: return "A";
            21'hE4, 21'hE0, 21'hE2, 21'hE3, 21'hE5, 21'h105: return "a";
            21'hD6, 21'hD2, 21'hD4, 21'hD5: return "O";
            21'hF6, 21'hF2, 21'hF4, 21'hF5: return "o";
            21'hDC, 21'hD9, 21'hDB: return "U";
            21'hFC, 21'hF9, 21'hFB: return "u";
            21'hDF: return "ss";
            21'hC8, 21'hCA, 21'hCB, 21'h118: return "E";
            21'hE8, 21'hEA, 21'hEB, 21'h119: return "e";
            21'hCC, 21'hCE, 21'hCF: return "I";
            21'hEC, 21'hEE, 21'hEF: return "i";
            21'hC7, 21'h106: return "C";
            21'hE7, 21'h107: return "c";
            21'hD1, 21'h143: return "N";
            21'hF1, 21'h144: return "n";
            21'h139, 21'h13D, 21'h141: return "L";
            21'h13A, 21'h13E, 21'h142: return "l";
            21'h154: return "R";
            21'h155: return "r";
            21'h15A: return "S";
            21'h15B: return "s";
            21'h179, 21'h17B: return "Z";
            21'h17A, 21'h17C: return "z";
            21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2015,
            21'h2212: return "-";
            21'h2018, 21'h2019, 21'h201A, 21'h201B: return "'";
            21'h201C, 21'h201D, 21'h201E, 21'h201F, 21'hAB, 21'hBB: return "\"";
            21'h2026: return "...";
            21'h20AC: return "EUR";
            21'hA9: return "(c)";
            default: return "";
        endcase
    endfunction

    function automatic void emit_code_point(logic [20:0] c);
        logic [2:0][7:0] s;
        string t;
        s = '0;
        if (c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D || c == 21'hA0 ||
            c == 21'h2007 || c == 21'h2009 || c == 21'h202F) begin
            if (p_any_written) p_space_pend = 1'b1;
            return;
        end
        if (glyph_in_font(c)) begin
            if (c < 21'h80) begin
                s[2] = c[7:0];
                put_seq(s, 1);
            end else if (c < 21'h800) begin
                s[2] = {3'b110, c[10:6]};
                s[1] = {2'b10, c[5:0]};
                put_seq(s, 2);
            end else begin
                s[2] = {4'hE, c[15:12]};
                s[1] = {2'b10, c[11:6]};
                s[0] = {2'b10, c[5:0]};
                put_seq(s, 3);
            end
            return;
        end
        t = ascii_fold(c);
        for (int i = 0; i < t.len(); i++) s[2-i] = t[i];
        put_seq(s, t.len());
    endfunction

    function automatic void replay_digits();
        for (int i = 0; i < p_hex_cnt && i < 3; i++) emit_code_point({13'd0, p_hex_held[i]});
        p_hex_cnt = 0;
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int d;
        if (p_mode == DEC_UTF8) begin
            if (b[7:6] == 2'b10) begin
                p_acc = {p_acc[14:0], b[5:0]};
                if (p_cont_left > 0) p_cont_left--;
                if (p_cont_left == 0) begin
                    p_mode = DEC_IDLE;
                    emit_code_point(p_acc);
                end
                return;
            end
            p_mode = DEC_IDLE;
        end else if (p_mode == DEC_ESC) begin
            p_mode = DEC_IDLE;
            if (b == "\"" || b == "\\" || b == "/") begin
                put_seq({b, 16'h0}, 1);
            end else if (b == "b" || b == "f" || b == "n" || b == "r" || b == "t") begin
                if (p_any_written) p_space_pend = 1'b1;
            end else if (b == "u") begin
                p_mode = DEC_HEX;
                p_hex_cnt = 0;
                p_acc = '0;
            end
            return;
        end else if (p_mode == DEC_HEX) begin
            d = hex_digit(b);
            if (d >= 0) begin
                p_acc = {5'd0, p_acc[11:0], d[3:0]};
                if (p_hex_cnt >= 3) begin
                    p_mode = DEC_IDLE;
                    p_hex_cnt = 0;
                    if (p_acc < 21'hD800 || p_acc > 21'hDFFF) emit_code_point(p_acc);
                end else begin
                    p_hex_held[p_hex_cnt] = b;
                    p_hex_cnt++;
                end
                return;
            end
            replay_digits();
            p_mode = DEC_IDLE;
        end
        if (b == "\\") begin
            p_mode = DEC_ESC;
        end else if (b < 8'h80) begin
            emit_code_point({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
            p_acc = {16'd0, b[4:0]}; p_cont_left = 2'd1; p_mode = DEC_UTF8;
        end else if (b[7:4] == 4'b1110) begin
            p_acc = {17'd0, b[3:0]}; p_cont_left = 2'd2; p_mode = DEC_UTF8;
        end else if (b[7:3] == 5'b11110) begin
            p_acc = {18'd0, b[2:0]}; p_cont_left = 2'd3; p_mode = DEC_UTF8;
        end
    endfunction

    function automatic void clear_text_state();
        p_mode = DEC_IDLE;
        p_cont_left = '0;
        p_acc = '0;
        p_hex_cnt = 0;
        p_written = '0;
        p_space_pend = 1'b0;
        p_any_written = 1'b0;
    endfunction

    function automatic void predict_transfer(t_src it);
        if (it.present) decode_byte(it.b);
        if (it.last) begin
            if (p_mode == DEC_HEX) replay_digits();
            push_write(8'h00, p_written, 1'b1, p_capacity != 0, 1'b1, p_written);
            clear_text_state();
        end
    endfunction

    // stimulus builders
    function automatic void add_item(logic [7:0] b, logic present, logic last);
        t_src it;
        it.b = b; it.present = present; it.last = last;
        src_q.push_back(it);
        n_items++;
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b1, 1'b0);
    endfunction

    function automatic void add_utf8(logic [15:0] c);
        if (c < 16'h80) begin
            add_item(c[7:0], 1'b1, 1'b0);
        end else if (c < 16'h800) begin
            add_item({3'b110, c[10:6]}, 1'b1, 1'b0);
            add_item({2'b10, c[5:0]}, 1'b1, 1'b0);
        end else begin
            add_item({4'hE, c[15:12]}, 1'b1, 1'b0);
            add_item({2'b10, c[11:6]}, 1'b1, 1'b0);
            add_item({2'b10, c[5:0]}, 1'b1, 1'b0);
        end
    endfunction

    function automatic logic [15:0] pick_code_point();
        logic [15:0] cps[20] = '{16'hE9, 16'h10C, 16'h17E, 16'h2082, 16'hC4, 16'hDF,
            16'h2026, 16'h20AC, 16'hA9, 16'h2013, 16'h201C, 16'hA0, 16'h202F, 16'h2009,
            16'h3A9, 16'hB0, 16'h142, 16'h16F, 16'h2007, 16'hFFFF};
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return cps[$urandom_range(0, 19)];
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 10) return "0" + v;
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    function automatic void add_random_text();
        int ntok;
        int k;
        logic [15:0] c;
        string esc = "\"\\/bfnrtqu";
        ntok = $urandom_range(1, 12);
        for (int t = 0; t < ntok; t++) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: add_item(8'($urandom_range(8'h20, 8'h7E)), 1'b1, 1'b0);
                4: add_item($urandom_range(0, 2) == 0 ? 8'h09 :
                            ($urandom_range(0, 1) ? 8'h0A : 8'h20), 1'b1, 1'b0);
                5: begin
                    add_item("\\", 1'b1, 1'b0);
                    add_item(esc[$urandom_range(0, 9)], 1'b1, 1'b0);
                end
                6: begin
                    c = $urandom_range(0, 3) == 0 ? 16'($urandom_range(16'hD800, 16'hDFFF))
                                                  : pick_code_point();
                    k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 4;
                    add_str("\\u");
                    for (int i = 0; i < k; i++) add_item(hex_char(c[15-4*i -: 4]), 1'b1, 1'b0);
                    if (k < 4 && $urandom_range(0, 1)) add_item("z", 1'b1, 1'b0);
                end
                7, 8: add_utf8(pick_code_point());
                9: begin
                    add_item(8'hF0 | 8'($urandom_range(0, 7)), 1'b1, 1'b0);
                    k = $urandom_range(0, 3);
                    for (int i = 0; i < k; i++)
                        add_item(8'h80 | 8'($urandom_range(0, 63)), 1'b1, 1'b0);
                end
                10: add_item(8'($urandom), 1'b1, 1'b0);
                default: add_item(8'($urandom), 1'b0, 1'b0);
            endcase
        end
        if ($urandom_range(0, 1)) add_item(8'($urandom), 1'b1, 1'b1);
        else add_item(8'($urandom), 1'b0, 1'b1);
    endfunction

    task automatic wait_idle();
        forever begin
            @(posedge i_clk);
            if (src_q.size() == 0 && !i_in_valid && dest_writes_q.size() == 0) break;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [9:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        p_capacity = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // source driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_transfer('{b: i_in_byte, present: i_byte_present, last: i_last_byte});
            if (!i_in_valid || !o_in_stall) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (src_q.size() > 0) begin
                    i_in_byte <= src_q[0].b;
                    i_byte_present <= src_q[0].present;
                    i_last_byte <= src_q[0].last;
                    void'(src_q.pop_front());
                    i_in_valid <= 1'b1;
                    src_gap <= $urandom_range(0, src_gap_max);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // destination monitor
    always @(posedge i_clk) begin
        t_wr w;
        int  d;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (dest_writes_q.size() == 0) begin
                    $display("%0t: unexpected transfer byte=%h pos=%0d", $time, o_out_byte,
                             o_position);
                    n_errors++;
                end else begin
                    w = dest_writes_q.pop_front();
                    if (o_out_byte !== w.b) begin
                        $display("%0t: out_byte exp %h got %h", $time, w.b, o_out_byte);
                        n_errors++;
                    end
                    if (o_position !== w.pos) begin
                        $display("%0t: position exp %0d got %0d", $time, w.pos, o_position);
                        n_errors++;
                    end
                    if (o_is_terminator !== w.term) begin
                        $display("%0t: is_terminator exp %b got %b", $time, w.term,
                                 o_is_terminator);
                        n_errors++;
                    end
                    if (o_store_enable !== w.st) begin
                        $display("%0t: store_enable exp %b got %b", $time, w.st,
                                 o_store_enable);
                        n_errors++;
                    end
                    if (o_last_result !== w.last) begin
                        $display("%0t: last_result exp %b got %b", $time, w.last,
                                 o_last_result);
                        n_errors++;
                    end
                    if (o_text_length !== w.len) begin
                        $display("%0t: text_length exp %0d got %0d", $time, w.len,
                                 o_text_length);
                        n_errors++;
                    end
                end
                d = $urandom_range(0, sink_stall_max);
                if (d > 0) begin
                    sink_stall <= d - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    sink_stall <= 0;
                    i_out_stall <= 1'b0;
                end
            end else if (sink_stall > 0) begin
                sink_stall <= sink_stall - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("json_text_to_font_utf8_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [9:0] caps[8] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd1023, 10'd8, 10'd5, 10'd20};
        int target;
        cycles = 0;
        n_items = 0;
        n_errors = 0;
        src_gap_max = 5;
        sink_stall_max = 5;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_in_byte = '0;
        i_byte_present = 1'b0;
        i_last_byte = 1'b0;
        i_out_stall = 1'b0;
        p_capacity = 10'd64;
        clear_text_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: escapes, failed and surrogate \u, bad UTF-8, font and folded chars
        add_str(" A\\\"\\\\\\/\\n \\qB\\u00E9\\uD800\\u12xC");
        add_item(8'hC3, 1'b1, 1'b0);
        add_item(8'h41, 1'b1, 1'b0);
        add_utf8(16'h2026);
        add_utf8(16'h20AC);
        add_str("\\t");
        add_item(8'hF0, 1'b1, 1'b0);
        add_str("\x9f\x98\x80");
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'h80, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_str("~ \\u4");
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);
        add_str("x\\");
        add_item(8'hE2, 1'b1, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            if (ph < 8) write_capacity(caps[ph]);
            else write_capacity(10'($urandom_range(4, 40)));
            src_gap_max = (ph % 3 == 1) ? 0 : 5;
            sink_stall_max = (ph % 4 == 2) ? 0 : 5;
            target = n_items + 36;
            while (n_items < target) add_random_text();
            wait_idle();
        end
        write_capacity(10'd64);
        src_gap_max = 2;
        sink_stall_max = 2;
        add_random_text();
        wait_idle();

        if (n_errors == 0) begin
            $display("json_text_to_font_utf8_tb OK");
        end else begin
            $display("json_text_to_font_utf8_tb NOT OK");
        end
        $finish;
    end
endmodule
